// ===== src/hte_pkg.sv =====
`timescale 1ns / 1ps
package hte_pkg;

  // Largest marker the datapath is built for, in bytes.
  localparam int MARK_CAP = 4;
  localparam int QUEUE_DEPTH = 4;

  // Configuration register indexes (byte address is four times the index).
  localparam logic [2:0] REG_HEAD_PATTERN = 3'd0;
  localparam logic [2:0] REG_HEAD_LENGTH  = 3'd1;
  localparam logic [2:0] REG_TAIL_PATTERN = 3'd2;
  localparam logic [2:0] REG_TAIL_LENGTH  = 3'd3;
  localparam logic [2:0] REG_BYPASS       = 3'd4;

  typedef struct packed {
    logic [7:0] data_in;
    logic       chunk_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic       frame_last;
  } out_item_t;

  typedef struct packed {
    logic [31:0] head_pattern;
    logic [2:0]  head_length;
    logic [31:0] tail_pattern;
    logic [2:0]  tail_length;
    logic        bypass;
  } cfg_t;

  // One queue entry: cnt bytes to emit, highest index first, last flag on the final one.
  typedef struct packed {
    logic [2:0]                cnt;
    logic [MARK_CAP-1:0][7:0]  bytes;
    logic                      last;
  } cmd_t;

endpackage

// ===== src/head_tail_frame_extractor_core.sv =====
`timescale 1ns / 1ps
// Throughput: one byte accepted and one result delivered per cycle while the queue is not
// full and the receiver is ready; a head match emits its 1 to 4 bytes from a four-entry queue,
// and a four-byte head can stall the input even with the receiver always ready.
// Reset (rst_n low, synchronous): configuration and control registers return to their reset
// values, the frame state goes back to searching for a head, and the queue and output are emptied.
module head_tail_frame_extractor_core #(
  parameter int MARK_MAX_BYTES = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  hte_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output hte_pkg::out_item_t out_data,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [4:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);
  import hte_pkg::*;

  localparam int MARK_LIM = (MARK_MAX_BYTES < 1) ? 1 :
                            (MARK_MAX_BYTES > MARK_CAP) ? MARK_CAP : MARK_MAX_BYTES;

  cfg_t       cfg_r;
  logic       cfg_wr;
  logic [2:0] reg_idx;
  logic       q_push, q_pop, q_full, q_empty;
  cmd_t       q_in, q_head;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.head_pattern <= '0;
      cfg_r.head_length  <= 3'd1;
      cfg_r.tail_pattern <= '0;
      cfg_r.tail_length  <= 3'd1;
      cfg_r.bypass       <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_HEAD_PATTERN: cfg_r.head_pattern <= cfg_pwdata;
        REG_HEAD_LENGTH:  cfg_r.head_length  <= cfg_pwdata[2:0];
        REG_TAIL_PATTERN: cfg_r.tail_pattern <= cfg_pwdata;
        REG_TAIL_LENGTH:  cfg_r.tail_length  <= cfg_pwdata[2:0];
        REG_BYPASS:       cfg_r.bypass       <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_HEAD_PATTERN: cfg_prdata = cfg_r.head_pattern;
      REG_HEAD_LENGTH:  cfg_prdata = {29'd0, cfg_r.head_length};
      REG_TAIL_PATTERN: cfg_prdata = cfg_r.tail_pattern;
      REG_TAIL_LENGTH:  cfg_prdata = {29'd0, cfg_r.tail_length};
      REG_BYPASS:       cfg_prdata = {31'd0, cfg_r.bypass};
      default:          cfg_prdata = '0;
    endcase
  end

  hte_front #(
    .MARK_LIM(MARK_LIM)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_data),
    .cfg      (cfg_r),
    .q_full   (q_full),
    .push     (q_push),
    .cmd      (q_in)
  );

  hte_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_in),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  hte_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .head      (q_head),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_data)
  );

endmodule

// ===== src/hte_front.sv =====
`timescale 1ns / 1ps
module hte_front #(
  parameter int MARK_LIM = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  hte_pkg::in_item_t in_item,
  input  hte_pkg::cfg_t     cfg,
  input  logic              q_full,
  output logic              push,
  output hte_pkg::cmd_t     cmd
);
  import hte_pkg::*;

  localparam int CW = $clog2(MARK_LIM + 1);

  logic [MARK_LIM-1:0][7:0] win_r, win_nxt, win_sh;
  logic [CW-1:0]            wc_r, wc_nxt, wc_inc;
  logic                     in_frame_r, in_frame_nxt;
  logic [2:0]               head_len, tail_len;
  logic                     head_hit, tail_hit, fire;

  function automatic logic [2:0] eff_len(input logic [2:0] len);
    logic [2:0] r;
    r = len;
    if (len == 3'd0) begin
      r = 3'd1;
    end else if (len > 3'(MARK_LIM)) begin
      r = 3'(MARK_LIM);
    end
    return r;
  endfunction

  assign in_ready = !q_full;
  assign fire     = in_valid && in_ready;
  assign head_len = eff_len(cfg.head_length);
  assign tail_len = eff_len(cfg.tail_length);

  always_comb begin
    win_sh[0] = in_item.data_in;
    for (int k = 1; k < MARK_LIM; k++) begin
      win_sh[k] = win_r[k-1];
    end
    wc_inc = (wc_r < CW'(MARK_LIM)) ? wc_r + CW'(1) : wc_r;
  end

  // Compare the window after the new byte has been shifted in; only the used bytes count.
  always_comb begin
    head_hit = (3'(wc_inc) >= head_len);
    tail_hit = (3'(wc_inc) >= tail_len);
    for (int k = 0; k < MARK_LIM; k++) begin
      if ((3'(k) < head_len) && (win_sh[k] != cfg.head_pattern[8*k +: 8])) begin
        head_hit = 1'b0;
      end
      if ((3'(k) < tail_len) && (win_sh[k] != cfg.tail_pattern[8*k +: 8])) begin
        tail_hit = 1'b0;
      end
    end
  end

  always_comb begin
    cmd          = '0;
    cmd.cnt      = 3'd1;
    cmd.bytes[0] = in_item.data_in;
    push         = 1'b0;
    win_nxt      = win_r;
    wc_nxt       = wc_r;
    in_frame_nxt = in_frame_r;
    if (cfg.bypass) begin
      push     = fire;
      cmd.last = in_item.chunk_last;
    end else if (!in_frame_r) begin
      push    = fire && head_hit;
      cmd.cnt = head_len;
      for (int k = 0; k < MARK_LIM; k++) begin
        cmd.bytes[k] = win_sh[k];
      end
      if (fire) begin
        if (head_hit) begin
          win_nxt      = '0;
          wc_nxt       = '0;
          in_frame_nxt = 1'b1;
        end else begin
          win_nxt = win_sh;
          wc_nxt  = wc_inc;
        end
      end
    end else begin
      push     = fire;
      cmd.last = tail_hit;
      if (fire) begin
        if (tail_hit) begin
          win_nxt      = '0;
          wc_nxt       = '0;
          in_frame_nxt = 1'b0;
        end else begin
          win_nxt = win_sh;
          wc_nxt  = wc_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r      <= '0;
      wc_r       <= '0;
      in_frame_r <= 1'b0;
    end else begin
      win_r      <= win_nxt;
      wc_r       <= wc_nxt;
      in_frame_r <= in_frame_nxt;
    end
  end

endmodule

// ===== src/hte_fifo.sv =====
`timescale 1ns / 1ps
module hte_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  hte_pkg::cmd_t push_cmd,
  input  logic          pop,
  output hte_pkg::cmd_t head,
  output logic          full,
  output logic          empty
);
  import hte_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          ent_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [NW-1:0] count_r, count_nxt;

  assign full  = (count_r == NW'(QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign head  = ent_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + NW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      count_r <= count_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue written while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("queue read while empty");
  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + NW'(1)))
    else $error("queue count did not follow a push");
`endif

endmodule

// ===== src/hte_back.sv =====
`timescale 1ns / 1ps
module hte_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  hte_pkg::cmd_t      head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output hte_pkg::out_item_t out_item
);
  import hte_pkg::*;

  localparam int SW = $clog2(MARK_CAP);

  logic [SW-1:0] pos_r, pos_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_item_r, out_item_nxt;
  logic          load, at_end;
  logic [2:0]    sel;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Bytes of an entry go out from the highest index down to index zero.
  assign load   = !q_empty && (!out_valid_r || out_ready);
  assign sel    = head.cnt - 3'd1 - 3'(pos_r);
  assign at_end = (3'(pos_r) == head.cnt - 3'd1);
  assign pop    = load && at_end;

  always_comb begin
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (load) begin
      out_valid_nxt           = 1'b1;
      out_item_nxt.data_out   = head.bytes[sel[SW-1:0]];
      out_item_nxt.frame_last = at_end && head.last;
      pos_nxt                 = at_end ? '0 : pos_r + SW'(1);
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_pos_in_entry: assert property (@(posedge clk) disable iff (!rst_n)
    !q_empty |-> (3'(pos_r) < head.cnt))
    else $error("byte position runs past the queue entry");
  a_pos_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    q_empty |-> (pos_r == '0))
    else $error("byte position left over with an empty queue");
`endif

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import hte_pkg::*;

  localparam int MARK_MAX_BYTES = 4;
  localparam int MARK_LIMIT = (MARK_MAX_BYTES < 1) ? 1 : (MARK_MAX_BYTES > 4) ? 4 : MARK_MAX_BYTES;
  // Index past the last register; writes there must change nothing.
  localparam logic [2:0] REG_SPARE = 3'd5;
  localparam int RANDOM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 38;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD = 120;
  localparam int CYCLE_LIMIT = 250000;

  class frame_scoreboard;
    logic [31:0] head_pat;
    logic [2:0]  head_len;
    logic [31:0] tail_pat;
    logic [2:0]  tail_len;
    logic        bypass_on;
    logic [31:0] recent_bytes;
    int          window_fill;
    logic        framing;
    out_item_t   expected_bytes[$];
    int          errors;
    int          checked;
    int          closed;

    function new();
      head_pat = '0;
      head_len = 3'd1;
      tail_pat = '0;
      tail_len = 3'd1;
      bypass_on = 1'b0;
      recent_bytes = '0;
      window_fill = 0;
      framing = 1'b0;
      errors = 0;
      checked = 0;
      closed = 0;
    endfunction

    function void set_register(logic [2:0] idx, logic [31:0] value);
      case (idx)
        REG_HEAD_PATTERN: head_pat = value;
        REG_HEAD_LENGTH:  head_len = value[2:0];
        REG_TAIL_PATTERN: tail_pat = value;
        REG_TAIL_LENGTH:  tail_len = value[2:0];
        REG_BYPASS:       bypass_on = value[0];
        default: ;
      endcase
    endfunction

    function int eff_length(logic [2:0] len);
      if (len == 0) return 1;
      if (len > MARK_LIMIT) return MARK_LIMIT;
      return len;
    endfunction

    function bit window_hit(logic [31:0] pat, int len);
      logic [63:0] mask;
      mask = (64'd1 << (8 * len)) - 64'd1;
      if (window_fill < len) return 1'b0;
      return (recent_bytes & mask[31:0]) == (pat & mask[31:0]);
    endfunction

    function void note_request(in_item_t req);
      out_item_t res;
      int hl;
      bit done;
      if (bypass_on) begin
        res.data_out = req.data_in;
        res.frame_last = req.chunk_last;
        expected_bytes = {expected_bytes, res};
        return;
      end
      recent_bytes = {recent_bytes[23:0], req.data_in};
      if (window_fill < MARK_LIMIT) window_fill++;
      if (!framing) begin
        hl = eff_length(head_len);
        if (!window_hit(head_pat, hl)) return;
        for (int k = 0; k < hl; k++) begin
          res.data_out = 8'(recent_bytes >> (8 * (hl - 1 - k)));
          res.frame_last = 1'b0;
          expected_bytes = {expected_bytes, res};
        end
        framing = 1'b1;
        recent_bytes = '0;
        window_fill = 0;
      end else begin
        done = window_hit(tail_pat, eff_length(tail_len));
        res.data_out = req.data_in;
        res.frame_last = done;
        expected_bytes = {expected_bytes, res};
        if (done) begin
          framing = 1'b0;
          recent_bytes = '0;
          window_fill = 0;
        end
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      checked++;
      if (got.frame_last) closed++;
      if (expected_bytes.size() == 0) begin
        $error("unexpected result: data_out %02h frame_last %0b", got.data_out, got.frame_last);
        errors++;
        return;
      end
      want = expected_bytes.pop_front();
      if (got.data_out !== want.data_out) begin
        $error("data_out: expected %02h, actual %02h", want.data_out, got.data_out);
        errors++;
      end
      if (got.frame_last !== want.frame_last) begin
        $error("frame_last: expected %0b, actual %0b", want.frame_last, got.frame_last);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b1;
  out_item_t   out_data;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  frame_scoreboard sb;
  int  sent_count = 0;
  int  setting_count = 0;
  int  cycle_count = 0;
  int  long_hold_cycles = 0;
  bit  tx_idle = 1'b1;
  bit  rx_idle = 1'b1;

  head_tail_frame_extractor_core #(.MARK_MAX_BYTES(MARK_MAX_BYTES)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_request(in_data);
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // Result side: random stalls, plus one long hold-off requested by the stimulus.
  initial begin
    forever begin
      @(posedge clk);
      if (long_hold_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (long_hold_cycles) @(posedge clk);
        long_hold_cycles = 0;
        out_ready <= 1'b1;
      end else if (rx_idle && $urandom_range(0, 6) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  function automatic logic coin_chunk_end();
    return $urandom_range(0, 3) == 0;
  endfunction

  task automatic send_request(input logic [7:0] b, input logic cl);
    if (tx_idle && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{data_in: b, chunk_last: cl};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
  endtask

  // Sends the first count bytes of a marker, first byte taken from the top used byte.
  task automatic send_marker(input logic [31:0] pat, input int len, input int count);
    for (int k = 0; k < count; k++) begin
      send_request(8'(pat >> (8 * (len - 1 - k))), coin_chunk_end());
    end
  endtask

  task automatic send_frame(input logic [31:0] hp, input logic [2:0] hl,
                            input logic [31:0] tp, input logic [2:0] tl);
    int shape;
    int he;
    int te;
    shape = $urandom_range(0, 9);
    he = sb.eff_length(hl);
    te = sb.eff_length(tl);
    repeat ($urandom_range(0, 3)) send_request(8'($urandom_range(0, 255)), coin_chunk_end());
    // A cut-short head leaves the extractor searching; a missing tail keeps the frame open.
    if (shape == 0) send_marker(hp, he, he - 1);
    else send_marker(hp, he, he);
    repeat ($urandom_range(0, 6)) send_request(8'($urandom_range(0, 255)), coin_chunk_end());
    if (shape != 1) send_marker(tp, te, te);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    sb.set_register(idx, value);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Stops offering requests until every expected byte is out and the pipeline is quiet.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [31:0] hp;
    logic [31:0] tp;
    logic [2:0]  hl;
    logic [2:0]  tl;
    logic        byp;
    int          phase_end;

    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    settle();

    // Reset values: zero markers of one byte, so 00 opens and closes a frame.
    setting_count++;
    send_request(8'h00, 1'b1);
    send_request(8'hFF, 1'b1);
    send_request(8'h00, 1'b0);
    settle();

    // Over-long head length clamps to four bytes, zero tail length counts as one.
    cfg_write(REG_HEAD_PATTERN, 32'hDEAD7E7E);
    cfg_write(REG_HEAD_LENGTH, 32'd7);
    cfg_write(REG_TAIL_PATTERN, 32'hFFFFFF0A);
    cfg_write(REG_TAIL_LENGTH, 32'd0);
    cfg_write(REG_SPARE, 32'hFFFFFFFF);
    setting_count++;
    send_request(8'h11, 1'b0);
    send_marker(32'hDEAD7E7E, 4, 4);
    send_request(8'h0A, 1'b1);
    send_marker(32'hDEAD7E7E, 4, 4);
    send_request(8'h42, 1'b0);
    settle();

    // Bypass in the middle of an open frame must leave the frame state alone.
    cfg_write(REG_BYPASS, 32'd1);
    setting_count++;
    send_request(8'hFF, 1'b1);
    send_request(8'h00, 1'b0);
    settle();
    cfg_write(REG_BYPASS, 32'd0);
    cfg_write(REG_TAIL_PATTERN, 32'hFFFF0D0A);
    cfg_write(REG_TAIL_LENGTH, 32'd2);
    setting_count++;
    send_request(8'h0D, 1'b0);
    send_request(8'h0A, 1'b0);
    settle();

    // Repeated AB bytes: the tail may not reuse head bytes, nor the next head the tail.
    cfg_write(REG_HEAD_PATTERN, 32'h1234ABAB);
    cfg_write(REG_HEAD_LENGTH, 32'd2);
    cfg_write(REG_TAIL_PATTERN, 32'h000000AB);
    cfg_write(REG_TAIL_LENGTH, 32'd1);
    setting_count++;
    repeat (5) send_request(8'hAB, 1'b0);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      hl = 3'($urandom_range(0, 7));
      tl = 3'($urandom_range(0, 7));
      byp = 1'b0;
      case (p)
        0: begin
          hl = 3'd1;
          tl = 3'd4;
        end
        1: begin
          hl = 3'd4;
          tl = 3'd1;
        end
        3: byp = 1'b1;
        5: begin
          hl = 3'd0;
          tl = 3'd7;
        end
        default: ;
      endcase
      if (p == RANDOM_PHASES - 1) begin
        tx_idle = 1'b0;
        rx_idle = 1'b0;
      end
      hp = $urandom;
      tp = $urandom;
      cfg_write(REG_HEAD_PATTERN, hp);
      cfg_write(REG_HEAD_LENGTH, 32'(hl));
      cfg_write(REG_TAIL_PATTERN, tp);
      cfg_write(REG_TAIL_LENGTH, 32'(tl));
      cfg_write(REG_BYPASS, 32'(byp));
      setting_count++;
      // The receiver stalls long enough for the extractor to back up into its input.
      if (p == 2) long_hold_cycles = LONG_HOLD;
      phase_end = sent_count + ITEMS_PER_PHASE;
      while (sent_count < phase_end) begin
        if (byp) send_request(8'($urandom_range(0, 255)), coin_chunk_end());
        else send_frame(hp, hl, tp, tl);
      end
    end

    settle();
    $display("Sent %0d requests under %0d register settings, frame and bypass modes,",
             sent_count, setting_count);
    $display("marker lengths 0 to 7; checked %0d result bytes, %0d flagged last.",
             sb.checked, sb.closed);
    if (sb.errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// ===== head_tail_frame_extractor_core.f =====
src/hte_pkg.sv
src/hte_front.sv
src/hte_fifo.sv
src/hte_back.sv
src/head_tail_frame_extractor_core.sv
dv/testbench.sv
